### rtl/core/nrgfe_pkg.sv
// Shared types, constants and codes for the NMEA RMC/GGA field extractor.
package nrgfe_pkg;

  localparam int MaxFieldChars = 16;  // usable range up to 16, as char_pos is 4 bits wide
  localparam int TagLen        = 5;
  localparam int TagIdxW       = 3;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharStar   = 8'h2A;

  localparam logic [7:0] RmcTag [TagLen] = '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43};  // GNRMC
  localparam logic [7:0] GgaTag [TagLen] = '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41};  // GNGGA

  // Field codes, the GGA satellites field index and counter limits
  localparam logic [3:0] FC_NONE   = 4'd0;
  localparam logic [3:0] FC_TIME   = 4'd1;
  localparam logic [3:0] FC_DATE   = 4'd9;
  localparam logic [3:0] FC_SATS   = 4'd10;
  localparam logic [3:0] GgaSatsField = 4'd7;
  localparam logic [3:0] CommaMax  = 4'd15;
  localparam logic [4:0] FciMax    = 5'd31;

  // Sentence end codes
  localparam logic [1:0] END_NONE = 2'd0;
  localparam logic [1:0] END_RMC  = 2'd1;
  localparam logic [1:0] END_GGA  = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TAG  = 2'd1,
    MODE_RMC  = 2'd2,
    MODE_GGA  = 2'd3
  } parse_mode_t;

  // Classified byte passed from front to back
  typedef struct packed {
    logic [7:0]        ch;
    logic              is_dollar;
    logic              is_comma;
    logic              is_star;
    logic [TagLen-1:0] rmc_hit;
    logic [TagLen-1:0] gga_hit;
  } cls_t;

  typedef struct packed {
    logic       capture_valid;
    logic [3:0] field_code;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic [1:0] sentence_end;
  } res_t;

endpackage

### rtl/core/nmea_rmc_gga_field_extractor.sv
// Top level of the NMEA RMC/GGA field extractor.
//
// Usage:
//   Input channel: one received ASCII byte per transfer on in_rx_byte, with
//   in_valid/in_stall. Output channel: exactly one result per input byte, on
//   the out_ field ports with out_valid/out_stall.
//   A '$' restarts tag matching against GNRMC and GNGGA. In a matched
//   sentence every character of a field of interest is reported with its
//   field code and position; '*' ends the sentence and is flagged on
//   out_sentence_end. Characters beyond the field length limit are dropped.
//   A byte passes through the queue and then the back end's output register
//   before its result is valid on the out_ ports.
//   Throughput: one byte per cycle while the receiver does not stall.
//   The front end classifies bytes into a two-entry queue; the back end pops
//   it whenever its output register is empty or being taken. If the receiver
//   stalls, the result holds, the queue fills and in_stall rises once full.
//   Reset (synchronous, rst_n low) empties the queue and output register and
//   returns the parser to idle, waiting for '$'.
module nmea_rmc_gga_field_extractor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_capture_valid,
  output logic [3:0] out_field_code,
  output logic [3:0] out_char_pos,
  output logic [7:0] out_char_value,
  output logic [1:0] out_sentence_end
);
  import nrgfe_pkg::*;

  cls_t front_cls;
  cls_t q_data;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  res_t res;

  // Classify the incoming byte
  nrgfe_front u_front (
    .rx_byte (in_rx_byte),
    .cls     (front_cls)
  );

  // Hold classified bytes until the back end can take them
  nrgfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  assign in_stall = q_full;

  // Advance the parser and register one result per byte
  nrgfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_not_empty),
    .item       (q_data),
    .item_pop   (q_pop),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res        (res)
  );

  assign out_capture_valid = res.capture_valid;
  assign out_field_code    = res.field_code;
  assign out_char_pos      = res.char_pos;
  assign out_char_value    = res.char_value;
  assign out_sentence_end  = res.sentence_end;

endmodule

### rtl/core/nrgfe_front.sv
// Front end: classify each received byte against delimiters and tag characters.
module nrgfe_front (
  input  logic [7:0]    rx_byte,
  output nrgfe_pkg::cls_t cls
);
  import nrgfe_pkg::*;

  always_comb begin
    cls.ch        = rx_byte;
    cls.is_dollar = (rx_byte == CharDollar);
    cls.is_comma  = (rx_byte == CharComma);
    cls.is_star   = (rx_byte == CharStar);
    for (int i = 0; i < TagLen; i++) begin
      cls.rmc_hit[i] = (rx_byte == RmcTag[i]);
      cls.gga_hit[i] = (rx_byte == GgaTag[i]);
    end
  end

endmodule

### rtl/core/nrgfe_queue.sv
// Short queue of classified bytes between front and back.
module nrgfe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nrgfe_pkg::cls_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output nrgfe_pkg::cls_t pop_data
);
  import nrgfe_pkg::*;

  cls_t                 mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QueueCntW-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full      = (count_r == QueueCntW'(QueueDepth));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/nrgfe_back.sv
// Back end: sentence parser state machine and registered result stage.
module nrgfe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  nrgfe_pkg::cls_t item,
  output logic            item_pop,
  output logic            res_valid,
  input  logic            res_stall,
  output nrgfe_pkg::res_t res
);
  import nrgfe_pkg::*;

  parse_mode_t        mode_r, mode_nxt;
  logic [TagIdxW-1:0] tag_idx_r, tag_idx_nxt;
  logic [1:0]         match_r, match_nxt;
  logic [3:0]         comma_r, comma_nxt;
  logic [4:0]         fci_r, fci_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;
  logic [1:0]         match_upd;
  logic [3:0]         fc;

  assign item_pop  = item_valid && (!out_valid_r || !res_stall);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    mode_nxt    = mode_r;
    tag_idx_nxt = tag_idx_r;
    match_nxt   = match_r;
    comma_nxt   = comma_r;
    fci_nxt     = fci_r;
    res_nxt     = res_r;
    match_upd   = '0;
    fc          = FC_NONE;
    out_valid_nxt = out_valid_r && res_stall;

    if (item_pop) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (item.is_dollar) begin
        // Restart tag matching wherever we are
        mode_nxt    = MODE_TAG;
        tag_idx_nxt = '0;
        match_nxt   = 2'b11;
        comma_nxt   = '0;
        fci_nxt     = '0;
      end else begin
        unique case (mode_r)
          MODE_IDLE: begin
          end
          MODE_TAG: begin
            if (tag_idx_r >= TagIdxW'(TagLen)) begin
              mode_nxt = MODE_IDLE;
            end else begin
              match_upd   = match_r & {item.gga_hit[tag_idx_r], item.rmc_hit[tag_idx_r]};
              match_nxt   = match_upd;
              tag_idx_nxt = tag_idx_r + 1'b1;
              if (match_upd == 2'b00) begin
                mode_nxt = MODE_IDLE;
              end else if (tag_idx_r == TagIdxW'(TagLen - 1)) begin
                mode_nxt  = match_upd[0] ? MODE_RMC : MODE_GGA;
                comma_nxt = '0;
                fci_nxt   = '0;
              end
            end
          end
          MODE_RMC, MODE_GGA: begin
            if (item.is_star) begin
              res_nxt.sentence_end = (mode_r == MODE_RMC) ? END_RMC : END_GGA;
              mode_nxt = MODE_IDLE;
            end else if (item.is_comma) begin
              if (comma_r < CommaMax) begin
                comma_nxt = comma_r + 1'b1;
              end
              fci_nxt = '0;
            end else begin
              if (mode_r == MODE_RMC) begin
                if (comma_r >= FC_TIME && comma_r <= FC_DATE) begin
                  fc = comma_r;
                end
              end else if (comma_r == GgaSatsField) begin
                fc = FC_SATS;
              end
              // Drop characters beyond the field length limit
              if (fc != FC_NONE && {1'b0, fci_r} < 6'(MaxFieldChars) && fci_r < FciMax) begin
                res_nxt.capture_valid = 1'b1;
                res_nxt.field_code    = fc;
                res_nxt.char_pos      = fci_r[3:0];
                res_nxt.char_value    = item.ch;
              end
              if (fci_r < FciMax) begin
                fci_nxt = fci_r + 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      tag_idx_r   <= '0;
      match_r     <= '0;
      comma_r     <= '0;
      fci_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      tag_idx_r   <= tag_idx_nxt;
      match_r     <= match_nxt;
      comma_r     <= comma_nxt;
      fci_r       <= fci_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
